// ----- rtl/swrms_pkg.sv -----
package swrms_pkg;

	// Storage and field sizes
	localparam int WINDOW_MAX  = 256;
	localparam int SAMPLE_BITS = 11;
	localparam int ADDR_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W       = SQ_W + LEN_W - 1;
	localparam int QUO_W       = SQ_W;
	localparam int ROOT_W      = 22;
	localparam int RMS_W       = 11;
	localparam int RMS_MAX     = 1024;

	// Division runs one quotient bit per cycle
	localparam int DIV_CNT_W   = $clog2(SUM_W);

	// Configuration port
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam logic REG_WINDOW_LEN = 1'b0;

	// Effective window length: zero acts as one, above the store saturates
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wlen);
		logic [LEN_W-1:0] res;
		if (wlen == '0) begin
			res = LEN_W'(1);
		end else if (wlen > LEN_W'(WINDOW_MAX)) begin
			res = LEN_W'(WINDOW_MAX);
		end else begin
			res = wlen;
		end
		return res;
	endfunction

endpackage

// ----- rtl/sliding_window_rms_top.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// input    | in_valid / in_stall  | sample (11 bit signed)
// output   | out_valid/ out_stall | rms (11 bit), window_full (1 bit)
// config   | APB psel/penable     | window_len at byte address 0 (9 bit)
//
// Each request runs through a read of the sample ring, squaring both samples and
// updating the sum, the bit-serial divider, the square root unit, loading the output
// register and an idle state before the next acceptance; the divider and the square
// root set the rate.
// Reset and any window_len write empty the window at once through per-entry
// valid bits; no clearing pass is needed.
// The finished result sits in an output register, so a new request is taken
// while the previous result is stalled; a second result waits in the last
// state until the output register frees up.
module sliding_window_rms_top
	import swrms_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [RMS_W-1:0]          rms,
	output logic                      window_full,

	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_SUB,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	state_t                    state_q;

	logic [LEN_W-1:0]          wlen_q;
	logic [LEN_W-1:0]          len_eff;
	logic [ADDR_W-1:0]         pos_q;
	logic [LEN_W-1:0]          fill_q;
	logic [SUM_W-1:0]          sum_q;
	logic [WINDOW_MAX-1:0]     vld_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic                      old_vld_q;
	logic [SQ_W-1:0]           prod_q;

	logic [LEN_W-1:0]          rem_q;
	logic [SUM_W-1:0]          quo_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;

	logic [QUO_W-1:0]          x_q;
	logic [ROOT_W-1:0]         res_q;
	logic [QUO_W-1:0]          bit_q;

	logic                      out_valid_q;
	logic [RMS_W-1:0]          rms_q;
	logic                      full_q;

	// Sample ring
	logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] mem_rd_q;
	logic                      mem_we;

	logic                      in_acc;
	logic                      out_acc;
	logic                      out_load;
	logic                      cfg_wr;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;
	logic [SUM_W-1:0]          sum_new;
	logic [LEN_W:0]            div_try;
	logic                      div_bit;
	logic [LEN_W-1:0]          rem_next;
	logic [SUM_W-1:0]          quo_next;
	logic [ROOT_W-1:0]         root_try;
	logic                      root_ge;

	assign len_eff  = eff_len(wlen_q);
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LEN);
	assign mem_we   = (state_q == ST_RD);

	// Square of whichever operand the current state needs
	assign sq_full  = (state_q == ST_RD) ? sample_q * sample_q : old_q * old_q;
	assign sum_new  = sum_q - SUM_W'(prod_q);

	// One restoring division step
	assign div_try  = {rem_q, quo_q[SUM_W-1]} - {1'b0, len_eff};
	assign div_bit  = !div_try[LEN_W];
	assign rem_next = div_bit ? div_try[LEN_W-1:0] : {rem_q[LEN_W-2:0], quo_q[SUM_W-1]};
	assign quo_next = {quo_q[SUM_W-2:0], div_bit};

	// One integer square root step
	assign root_try = res_q + ROOT_W'(bit_q);
	assign root_ge  = ROOT_W'(x_q) >= root_try;

	// Read and write the sample ring
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q] <= sample_q;
		end
		mem_rd_q <= mem[pos_q];
	end

	// Sequencer, running state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= LEN_W'(WINDOW_MAX);
			pos_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sample_q  <= sample;
						old_vld_q <= vld_q[pos_q];
						state_q   <= ST_RD;
					end
				end
				ST_RD: begin
					old_q        <= old_vld_q ? mem_rd_q : '0;
					prod_q       <= sq_full[SQ_W-1:0];
					vld_q[pos_q] <= 1'b1;
					state_q      <= ST_MUL;
				end
				ST_MUL: begin
					sum_q   <= sum_q + SUM_W'(prod_q);
					prod_q  <= sq_full[SQ_W-1:0];
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					sum_q     <= sum_new;
					rem_q     <= '0;
					quo_q     <= sum_new;
					div_cnt_q <= DIV_CNT_W'(SUM_W - 1);
					if (LEN_W'(pos_q) + LEN_W'(1) >= len_eff) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + ADDR_W'(1);
					end
					if (fill_q < len_eff) begin
						fill_q <= fill_q + LEN_W'(1);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q     <= rem_next;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						x_q     <= quo_next[QUO_W-1:0];
						res_q   <= '0;
						bit_q   <= {1'b1, {(QUO_W-1){1'b0}}};
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (root_ge) begin
						x_q   <= x_q - root_try[QUO_W-1:0];
						res_q <= (res_q >> 1) + ROOT_W'(bit_q);
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hold until the output register is free
					if (out_load) begin
						rms_q   <= res_q[RMS_W-1:0];
						full_q  <= (fill_q >= len_eff);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Start a new, empty window on a length write
			if (cfg_wr) begin
				wlen_q <= pwdata[LEN_W-1:0];
				pos_q  <= '0;
				fill_q <= '0;
				sum_q  <= '0;
				vld_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign rms         = rms_q;
	assign window_full = full_q;
	assign pready      = 1'b1;
	assign prdata      = (paddr[2] == REG_WINDOW_LEN) ? PDATA_W'(wlen_q) : '0;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_eff)
		else $error("fill count beyond window length");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(pos_q) < len_eff)
		else $error("write position outside window");

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_RD)
		else $error("accepted request did not start a ring read");

	a_rms_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rms <= RMS_W'(RMS_MAX))
		else $error("rms result out of range");
`endif

endmodule

// ----- verif/sliding_window_rms_top_tb.sv -----
module sliding_window_rms_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swrms_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_WINDOW_LEN = PADDR_W'(4 * REG_WINDOW_LEN);
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = PADDR_W'(4);
	localparam int                 CYCLE_LIMIT     = 600000;
	localparam int                 GAP_MAX         = 14;
	localparam int                 HOLD_CYCLES     = 700;
	localparam int                 TAIL_CYCLES     = 60;
	localparam int                 PHASES          = 9;

	typedef struct packed {
		logic [RMS_W-1:0] rms;
		logic             full;
	} rms_res_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {STYLE_MIXED, STYLE_LOUD, STYLE_QUIET} sample_style_t;

	typedef struct {
		row_kind_t                     kind;
		logic [PADDR_W-1:0]            addr;
		logic [LEN_W-1:0]              wlen;
		logic signed [SAMPLE_BITS-1:0] smp;
		bit                            known;
		rms_res_t                      res;
	} plan_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          out_valid;
	logic                          out_stall;
	logic [RMS_W-1:0]              rms;
	logic                          window_full;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [PADDR_W-1:0]            paddr;
	logic [PDATA_W-1:0]            pwdata;
	logic [PDATA_W-1:0]            prdata;
	logic                          pready;

	// Meter model state
	logic signed [SAMPLE_BITS-1:0] ring_model [WINDOW_MAX];
	int unsigned                   ring_pos;
	int unsigned                   ring_fill;
	longint unsigned               sq_total;
	logic [LEN_W-1:0]              wlen_reg;

	rms_res_t    rms_expect_q [$];
	plan_row_t   plan_q [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          hold_rx = 1'b0;
	bit          pressure_armed = 1'b0;

	int unsigned   phase_wlen  [PHASES] = '{1, 0, 2, 511, 3, 256, 255, 0, 0};
	int unsigned   phase_count [PHASES] = '{80, 50, 100, 320, 90, 300, 120, 120, 120};
	sample_style_t phase_style [PHASES] = '{STYLE_MIXED, STYLE_LOUD, STYLE_QUIET, STYLE_LOUD,
		STYLE_MIXED, STYLE_LOUD, STYLE_MIXED, STYLE_QUIET, STYLE_MIXED};

	sliding_window_rms_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rms        (rms),
		.window_full(window_full),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatch_count++;
	endtask

	// Empty the window: store, position, fill count and sum
	function automatic void clear_window_model();
		foreach (ring_model[i]) ring_model[i] = '0;
		ring_pos  = 0;
		ring_fill = 0;
		sq_total  = 0;
	endfunction

	function automatic int unsigned window_span();
		if (wlen_reg == '0) return 1;
		if (wlen_reg > LEN_W'(WINDOW_MAX)) return WINDOW_MAX;
		return wlen_reg;
	endfunction

	// Build the root bit by bit from the top, keeping each bit whose square still fits
	function automatic logic [RMS_W-1:0] int_root(input longint unsigned q);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = RMS_W - 1; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= q) r = trial;
		end
		return RMS_W'(r);
	endfunction

	// Replace the oldest sample, update the square sum and derive the meter reading
	function automatic rms_res_t rms_meter_step(input logic signed [SAMPLE_BITS-1:0] s);
		int unsigned span;
		int unsigned pos;
		longint      cur;
		longint      old;
		rms_res_t    r;
		span = window_span();
		pos  = ring_pos % span;
		cur  = s;
		old  = ring_model[pos];
		ring_model[pos] = s;
		sq_total = longint'(sq_total) + cur * cur - old * old;
		ring_pos = (pos + 1 >= span) ? 0 : pos + 1;
		if (ring_fill < span) ring_fill++;
		r.rms  = int_root(sq_total / span);
		r.full = (ring_fill >= span);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input sample_style_t style);
		int pick;
		pick = $urandom_range(0, 9);
		case (style)
			STYLE_LOUD: begin
				if (pick < 4) return SAMPLE_BITS'(-1024);
				if (pick < 7) return SAMPLE_BITS'(1023);
				return SAMPLE_BITS'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(800, 1023));
			end
			STYLE_QUIET: begin
				return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
			end
			default: begin
				case (pick)
					0: return SAMPLE_BITS'(-1024);
					1: return SAMPLE_BITS'(1023);
					2: return '0;
					default: return SAMPLE_BITS'($urandom_range(0, 2047));
				endcase
			end
		endcase
	endfunction

	function automatic void add_sample(input int s, input bit known, input int r, input bit f);
		plan_row_t row;
		row.kind     = ROW_SAMPLE;
		row.addr     = '0;
		row.wlen     = '0;
		row.smp      = SAMPLE_BITS'(s);
		row.known    = known;
		row.res.rms  = RMS_W'(r);
		row.res.full = f;
		plan_q.push_back(row);
	endfunction

	function automatic void add_write(input logic [PADDR_W-1:0] addr, input int unsigned wlen);
		plan_row_t row;
		row.kind  = ROW_WRITE;
		row.addr  = addr;
		row.wlen  = LEN_W'(wlen);
		row.smp   = '0;
		row.known = 1'b0;
		row.res   = '0;
		plan_q.push_back(row);
	endfunction

	// Offer one request after a random gap; hold it until taken, then log the expected reading
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit known,
			input rms_res_t typed);
		int       gap;
		rms_res_t predicted;
		gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (in_stall);
		predicted = rms_meter_step(s);
		rms_expect_q.push_back(known ? typed : predicted);
		@(negedge clk);
	endtask

	// Drop valid and wait until every outstanding request has returned
	task automatic finish_requests();
		in_valid <= 1'b0;
		while (rms_expect_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [LEN_W-1:0] wlen);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[LEN_W-1:0] = wlen;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_WINDOW_LEN) begin
			wlen_reg = word[LEN_W-1:0];
			clear_window_model();
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_read_check();
		logic [PDATA_W-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_WINDOW_LEN;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== PDATA_W'(wlen_reg))
			report_mismatch($sformatf("window_len read %0d, want %0d", got, wlen_reg));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sliding_window_rms_top test failed");
			$finish;
		end
	end

	// Compare each delivered reading against the oldest expectation
	always @(posedge clk) begin : result_check
		rms_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rms_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result rms=%0d full=%0b", rms, window_full));
			end else begin
				want = rms_expect_q.pop_front();
				if (rms !== want.rms)
					report_mismatch($sformatf("rms %0d, want %0d", rms, want.rms));
				if (window_full !== want.full)
					report_mismatch($sformatf("window_full %0b, want %0b", window_full, want.full));
			end
		end
	end

	// Receiver: random stall per result, extended while a long hold-off is active
	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
			if (gap > 0 || hold_rx) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
				while (hold_rx) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Long hold-off on the result side so the meter backs up and stalls its input
	initial begin : result_hold
		wait (pressure_armed);
		repeat ($urandom_range(300, 3000)) @(posedge clk);
		hold_rx = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin : stimulus
		plan_row_t row;
		rms_res_t  typed;
		int unsigned wlen;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample    = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		wlen_reg  = LEN_W'(WINDOW_MAX);
		clear_window_model();

		// Directed rows: reset window, single-entry window, saturation, wrap, unmapped write
		add_sample(0, 1, 0, 0);
		add_sample(-1024, 1, 64, 0);
		add_sample(-1024, 1, 90, 0);
		add_sample(1023, 0, 0, 0);
		add_sample(1, 0, 0, 0);
		add_sample(-1, 0, 0, 0);
		add_sample(682, 0, 0, 0);
		add_sample(-683, 0, 0, 0);
		add_write(ADDR_WINDOW_LEN, 0);
		add_sample(-1024, 1, 1024, 1);
		add_sample(1023, 1, 1023, 1);
		add_sample(0, 1, 0, 1);
		add_sample(-1, 1, 1, 1);
		add_write(ADDR_WINDOW_LEN, 1);
		add_sample(-1024, 1, 1024, 1);
		add_write(ADDR_WINDOW_LEN, 511);
		add_sample(0, 1, 0, 0);
		add_sample(-1024, 1, 64, 0);
		add_write(ADDR_WINDOW_LEN, 2);
		add_sample(-1024, 0, 0, 0);
		add_sample(-1024, 1, 1024, 1);
		add_sample(1023, 0, 0, 0);
		add_write(ADDR_UNMAPPED, $urandom_range(0, 511));
		add_sample(1023, 1, 1023, 1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		cfg_read_check();

		// Walk the directed table
		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.kind == ROW_WRITE) begin
				finish_requests();
				cfg_write(row.addr, row.wlen);
				if (row.addr == ADDR_WINDOW_LEN) cfg_read_check();
			end else begin
				send_sample(row.smp, row.known, row.res);
			end
		end

		// Random phases, each with its own window length and sample style
		typed = '0;
		pressure_armed = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			finish_requests();
			wlen = (p >= 7) ? $urandom_range(4, 200) : phase_wlen[p];
			cfg_write(ADDR_WINDOW_LEN, LEN_W'(wlen));
			cfg_read_check();
			tx_idle_on = (p % 3) != 1;
			rx_idle_on = (p % 4) != 2;
			for (int n = 0; n < phase_count[p]; n++)
				send_sample(next_sample(phase_style[p]), 1'b0, typed);
		end

		finish_requests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sliding_window_rms_top test passed");
		else
			$display("sliding_window_rms_top test failed");
		$finish;
	end

endmodule
